### design/v3au_pkg.sv
package v3au_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int LANES       = 3;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = FRAC_BITS + 1;
    localparam int LEN_W       = 33;
    localparam int DIV_W       = LEN_W + FRAC_BITS;
    localparam int NORM_W      = FRAC_BITS + 2;
    localparam int SIDE_DEPTH  = SQRT_STAGES + DIV_STAGES + 1;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_SCALE = 4'd2,
        MODE_DOT   = 4'd3,
        MODE_CROSS = 4'd4,
        MODE_LENSQ = 4'd5,
        MODE_LEN   = 4'd6,
        MODE_NORM  = 4'd7,
        MODE_COS   = 4'd8
    } mode_e;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } sat_t;

    // work carried alongside the length and divide pipelines
    typedef struct packed {
        mode_e                  mode;
        logic [LANES-1:0][31:0] vec;
        logic [31:0]            rs;
        logic                   sat;
        logic [LANES-1:0][31:0] mag_a;
        logic [LANES-1:0][31:0] mag_b;
        logic [LANES-1:0]       neg_a;
        logic [LANES-1:0]       neg_b;
    } side_t;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] rs;
        logic        sat;
        logic        zl;
    } res_t;

    function automatic sat_t clamp32(input logic signed [65:0] v);
        sat_t r;
        r.sat = 1'b1;
        if (v > SAT_MAX) begin
            r.val = 32'h7fffffff;
        end else if (v < SAT_MIN) begin
            r.val = 32'h80000000;
        end else begin
            r.val = v[31:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

### design/v3au_lane.sv
module v3au_lane import v3au_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  mode_e                    mode,
    input  logic signed [31:0]       ai,
    input  logic signed [31:0]       bi,
    input  logic signed [31:0]       aj,
    input  logic signed [31:0]       bj,
    input  logic signed [31:0]       ak,
    input  logic signed [31:0]       bk,
    input  logic signed [31:0]       f,
    output logic signed [63:0]       p0,
    output logic signed [63:0]       sqb,
    output logic [31:0]              vec,
    output logic                     vsat,
    output logic [31:0]              mag_a,
    output logic [31:0]              mag_b,
    output logic                     neg_a,
    output logic                     neg_b
);

    logic signed [31:0] op;
    logic signed [63:0] p0_reg, sqb_reg, c1_reg, c2_reg;
    logic signed [63:0] p0_next;
    logic signed [32:0] sum_reg, sum_next;
    mode_e              mode_reg;
    logic [31:0]        ma_reg, mb_reg, ma2_reg, mb2_reg;
    logic               na_reg, nb_reg, na2_reg, nb2_reg;
    logic [31:0]        vec_reg;
    logic               vsat_reg;
    logic signed [64:0] cdiff;
    sat_t               cv;

    always_comb begin
        unique case (mode) inside
            MODE_SCALE: op = f;
            MODE_DOT:   op = bi;
            default:    op = ai;
        endcase
        p0_next  = ai * op;
        sum_next = (mode == MODE_SUB) ? 33'(ai) - 33'(bi) : 33'(ai) + 33'(bi);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg   <= p0_next;
            sqb_reg  <= bi * bi;
            c1_reg   <= aj * bk;
            c2_reg   <= ak * bj;
            sum_reg  <= sum_next;
            mode_reg <= mode;
            ma_reg   <= ai[31] ? 32'(-ai) : 32'(ai);
            mb_reg   <= bi[31] ? 32'(-bi) : 32'(bi);
            na_reg   <= ai[31];
            nb_reg   <= bi[31];
        end
    end

    always_comb begin
        cdiff = 65'(c1_reg) - 65'(c2_reg);
        unique case (mode_reg) inside
            MODE_ADD, MODE_SUB: cv = clamp32(66'(sum_reg));
            MODE_SCALE:         cv = clamp32(66'(p0_reg >>> FRAC_BITS));
            MODE_CROSS:         cv = clamp32(66'(cdiff >>> FRAC_BITS));
            default:            cv = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vec_reg  <= cv.val;
            vsat_reg <= cv.sat;
            ma2_reg  <= ma_reg;
            mb2_reg  <= mb_reg;
            na2_reg  <= na_reg;
            nb2_reg  <= nb_reg;
        end
    end

    assign p0    = p0_reg;
    assign sqb   = sqb_reg;
    assign vec   = vec_reg;
    assign vsat  = vsat_reg;
    assign mag_a = ma2_reg;
    assign mag_b = mb2_reg;
    assign neg_a = na2_reg;
    assign neg_b = nb2_reg;

endmodule

### design/v3au_sqrt.sv
module v3au_sqrt import v3au_pkg::*; (
    input  logic             aclk,
    input  logic             en,
    input  logic [63:0]      x,
    output logic [LEN_W-1:0] root
);

    logic [63:0] x_reg   [1:SQRT_STAGES-1];
    logic [63:0] res_reg [1:SQRT_STAGES];

    // one root bit per stage, same recurrence as the classic bit-pair method
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] xi, ri, x_next, res_next, trial;

        if (k == 0) begin : g_first
            assign xi = x;
            assign ri = '0;
        end else begin : g_rest
            assign xi = x_reg[k];
            assign ri = res_reg[k];
        end

        always_comb begin
            trial = ri + BIT;
            if (xi >= trial) begin
                x_next   = xi - trial;
                res_next = (ri >> 1) + BIT;
            end else begin
                x_next   = xi;
                res_next = ri >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[k+1] <= res_next;
            end
        end

        if (k < SQRT_STAGES - 1) begin : g_x
            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k+1] <= x_next;
                end
            end
        end
    end

    assign root = res_reg[SQRT_STAGES][LEN_W-1:0];

endmodule

### design/v3au_div.sv
module v3au_div import v3au_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [31:0]              mag,
    input  logic                     neg,
    input  logic [LEN_W-1:0]         len,
    output logic signed [NORM_W-1:0] n
);

    logic [DIV_W-1:0]   rem_reg [1:DIV_STAGES-1];
    logic [LEN_W-1:0]   len_reg [1:DIV_STAGES-1];
    logic [FRAC_BITS:0] q_reg   [1:DIV_STAGES];
    logic               neg_reg [1:DIV_STAGES];
    logic [NORM_W-1:0]  qext;

    // restoring division, quotient msb first, one bit per stage
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        localparam int BP = DIV_STAGES - 1 - k;
        logic [DIV_W-1:0]   ri, rem_next, divs;
        logic [LEN_W-1:0]   li;
        logic [FRAC_BITS:0] qi, q_next;
        logic               ni;

        if (k == 0) begin : g_first
            assign ri = DIV_W'(mag) << FRAC_BITS;
            assign li = len;
            assign qi = '0;
            assign ni = neg;
        end else begin : g_rest
            assign ri = rem_reg[k];
            assign li = len_reg[k];
            assign qi = q_reg[k];
            assign ni = neg_reg[k];
        end

        always_comb begin
            divs = DIV_W'(li) << BP;
            if (ri >= divs) begin
                rem_next = ri - divs;
                q_next   = qi | ((FRAC_BITS + 1)'(1) << BP);
            end else begin
                rem_next = ri;
                q_next   = qi;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[k+1]   <= q_next;
                neg_reg[k+1] <= ni;
            end
        end

        if (k < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    len_reg[k+1] <= li;
                end
            end
        end
    end

    assign qext = {1'b0, q_reg[DIV_STAGES]};
    assign n    = neg_reg[DIV_STAGES] ? -$signed(qext) : $signed(qext);

endmodule

### design/v3au_merge.sv
module v3au_merge import v3au_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fin_valid,
    input  side_t                    side,
    input  logic [LEN_W-1:0]         len_a,
    input  logic [LEN_W-1:0]         len_b,
    input  logic signed [NORM_W-1:0] na [LANES],
    input  logic signed [NORM_W-1:0] nb [LANES],
    output logic                     en,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [127:0]             m_tdata,
    output logic [1:0]               m_tuser
);

    logic signed [NORM_W-1:0]   n_reg    [LANES];
    logic signed [2*NORM_W-1:0] prod_reg [LANES];
    logic signed [65:0]         csum;
    sat_t                       cs;
    res_t                       fin, out_reg, skid_reg;
    logic                       out_v_reg, skid_v_reg;

    assign en = !skid_v_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < LANES; i++) begin
                n_reg[i]    <= na[i];
                prod_reg[i] <= na[i] * nb[i];
            end
        end
    end

    always_comb begin
        csum = 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2]);
        cs   = clamp32(csum >>> FRAC_BITS);
        fin  = '0;
        unique case (side.mode) inside
            MODE_ADD, MODE_SUB, MODE_SCALE, MODE_DOT, MODE_CROSS, MODE_LENSQ: begin
                fin.rx  = side.vec[0];
                fin.ry  = side.vec[1];
                fin.rz  = side.vec[2];
                fin.rs  = side.rs;
                fin.sat = side.sat;
            end
            MODE_LEN: begin
                if (len_a > {1'b0, 32'h7fffffff}) begin
                    fin.rs  = 32'h7fffffff;
                    fin.sat = 1'b1;
                end else begin
                    fin.rs = len_a[31:0];
                end
            end
            MODE_NORM: begin
                if (len_a == '0) begin
                    fin.zl = 1'b1;
                end else begin
                    // unit components stay well inside 32 bits
                    fin.rx = 32'(n_reg[0]);
                    fin.ry = 32'(n_reg[1]);
                    fin.rz = 32'(n_reg[2]);
                end
            end
            MODE_COS: begin
                if (len_a == '0 || len_b == '0) begin
                    fin.zl = 1'b1;
                end else begin
                    fin.rs  = cs.val;
                    fin.sat = cs.sat;
                end
            end
            default: fin = '0;
        endcase
    end

    // output register plus one skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_tready) begin
                out_reg    <= skid_reg;
                skid_v_reg <= 1'b0;
            end
        end else if (fin_valid) begin
            if (!out_v_reg || m_tready) begin
                out_reg   <= fin;
                out_v_reg <= 1'b1;
            end else begin
                skid_reg   <= fin;
                skid_v_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {out_reg.rs, out_reg.rz, out_reg.ry, out_reg.rx};
    assign m_tuser  = {out_reg.zl, out_reg.sat};

endmodule

### design/vector3_arithmetic_unit_top.sv
// three-component vector alu, signed fixed point with FRAC_BITS fraction bits
// input channel s_*: one item per handshake, s_tuser carries the mode code
// (add, sub, scale, dot, cross, squared length, length, normalize, cosine)
// and s_tdata the two vectors and the scale factor
// result channel m_*: one item per input item, in order, m_tdata carries
// the vector result and the scalar result, m_tuser the saturated and
// zero-length flags
// every item passes the same fixed pipeline: 2 product/merge stages, a
// 32-stage square root, a FRAC_BITS+1 stage divider and 2 cosine/select
// stages before its result shows on m_tvalid
// throughput is one item per cycle unless stalled; the length and divide
// units are fully pipelined, one root bit and one quotient bit per stage
// a stalled receiver fills the output register and one skid entry, then
// s_tready drops and the whole pipeline holds until m_tready returns
// reset clears all valid flags; no state is kept between items
module vector3_arithmetic_unit_top import v3au_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax, ay, az, bx, by, bz, factor (32 bits each, from bit 0 up)
    input  logic [223:0] s_tdata,
    // mode
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rx, ry, rz, rscalar (32 bits each, from bit 0 up)
    output logic [127:0] m_tdata,
    // saturated, zero_length
    output logic [1:0]   m_tuser
);

    logic                     en;
    logic signed [31:0]       a_in [LANES];
    logic signed [31:0]       b_in [LANES];
    logic signed [31:0]       f_in;
    mode_e                    mode_in;

    logic signed [63:0]       p0  [LANES];
    logic signed [63:0]       sqb [LANES];
    logic [31:0]              vec [LANES];
    logic [LANES-1:0]         vsat;
    logic [31:0]              mag_a [LANES];
    logic [31:0]              mag_b [LANES];
    logic [LANES-1:0]         neg_a, neg_b;

    logic                     valid1_reg, valid2_reg;
    mode_e                    mode1_reg, mode2_reg;
    sat_t                     scal_reg, scal_next;
    logic signed [65:0]       psum;
    logic [63:0]              lsa_reg, lsb_reg;

    side_t                    s2;
    side_t                    sd_reg [1:SIDE_DEPTH];
    logic                     v_reg  [1:SIDE_DEPTH];

    logic [LEN_W-1:0]         root_a, root_b;
    logic [LEN_W-1:0]         lena_reg [1:DIV_STAGES+1];
    logic [LEN_W-1:0]         lenb_reg [1:DIV_STAGES+1];
    logic signed [NORM_W-1:0] na [LANES];
    logic signed [NORM_W-1:0] nb [LANES];

    assign s_tready = en;
    assign mode_in  = mode_e'(s_tuser);
    assign f_in     = s_tdata[192 +: 32];

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        assign a_in[i] = s_tdata[32*i +: 32];
        assign b_in[i] = s_tdata[32*(i+LANES) +: 32];

        v3au_lane u_lane (
            .aclk  (aclk),
            .en    (en),
            .mode  (mode_in),
            .ai    (a_in[i]),
            .bi    (b_in[i]),
            .aj    (a_in[(i+1)%LANES]),
            .bj    (b_in[(i+1)%LANES]),
            .ak    (a_in[(i+2)%LANES]),
            .bk    (b_in[(i+2)%LANES]),
            .f     (f_in),
            .p0    (p0[i]),
            .sqb   (sqb[i]),
            .vec   (vec[i]),
            .vsat  (vsat[i]),
            .mag_a (mag_a[i]),
            .mag_b (mag_b[i]),
            .neg_a (neg_a[i]),
            .neg_b (neg_b[i])
        );
    end

    // cross-lane sums: dot and squared length, raw squared lengths
    always_comb begin
        psum = 66'(p0[0]) + 66'(p0[1]) + 66'(p0[2]);
        if (mode1_reg == MODE_DOT || mode1_reg == MODE_LENSQ) begin
            scal_next = clamp32(psum >>> FRAC_BITS);
        end else begin
            scal_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else if (en) begin
            valid1_reg <= s_tvalid;
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode_in;
            mode2_reg <= mode1_reg;
            scal_reg  <= scal_next;
            lsa_reg   <= 64'(p0[0]) + 64'(p0[1]) + 64'(p0[2]);
            lsb_reg   <= 64'(sqb[0]) + 64'(sqb[1]) + 64'(sqb[2]);
        end
    end

    always_comb begin
        s2.mode = mode2_reg;
        s2.rs   = scal_reg.val;
        s2.sat  = scal_reg.sat | (|vsat);
        for (int i = 0; i < LANES; i++) begin
            s2.vec[i]   = vec[i];
            s2.mag_a[i] = mag_a[i];
            s2.mag_b[i] = mag_b[i];
            s2.neg_a[i] = neg_a[i];
            s2.neg_b[i] = neg_b[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= SIDE_DEPTH; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[1] <= valid2_reg;
            for (int k = 2; k <= SIDE_DEPTH; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[1] <= s2;
            for (int k = 2; k <= SIDE_DEPTH; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    v3au_sqrt u_sqrt_a (.aclk(aclk), .en(en), .x(lsa_reg), .root(root_a));
    v3au_sqrt u_sqrt_b (.aclk(aclk), .en(en), .x(lsb_reg), .root(root_b));

    always_ff @(posedge aclk) begin
        if (en) begin
            lena_reg[1] <= root_a;
            lenb_reg[1] <= root_b;
            for (int k = 2; k <= DIV_STAGES + 1; k++) begin
                lena_reg[k] <= lena_reg[k-1];
                lenb_reg[k] <= lenb_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_div
        v3au_div u_div_a (
            .aclk (aclk),
            .en   (en),
            .mag  (sd_reg[SQRT_STAGES].mag_a[i]),
            .neg  (sd_reg[SQRT_STAGES].neg_a[i]),
            .len  (root_a),
            .n    (na[i])
        );
        v3au_div u_div_b (
            .aclk (aclk),
            .en   (en),
            .mag  (sd_reg[SQRT_STAGES].mag_b[i]),
            .neg  (sd_reg[SQRT_STAGES].neg_b[i]),
            .len  (root_b),
            .n    (nb[i])
        );
    end

    v3au_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (v_reg[SIDE_DEPTH]),
        .side      (sd_reg[SIDE_DEPTH]),
        .len_a     (lena_reg[DIV_STAGES+1]),
        .len_b     (lenb_reg[DIV_STAGES+1]),
        .na        (na),
        .nb        (nb),
        .en        (en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
